// ===== design/enhanced_clock_page_victim_assert.svh =====
// Assertion helpers; clk and rst must be in scope where these are used.
`ifndef ENHANCED_CLOCK_PAGE_VICTIM_ASSERT_SVH
`define ENHANCED_CLOCK_PAGE_VICTIM_ASSERT_SVH

`define ECPV_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ECPV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ECPV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ecpv_pkg.sv =====
package ecpv_pkg;

  localparam int FRAME_W = 6;
  localparam int ENTRY_W = 4;

  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_MARKED = 2'd2;

  localparam logic [2:0] PASS_FREE   = 3'd0;
  localparam logic [2:0] PASS_CLEAN1 = 3'd1;
  localparam logic [2:0] PASS_DIRTY1 = 3'd2;
  localparam logic [2:0] PASS_CLEAN2 = 3'd3;
  localparam logic [2:0] PASS_DIRTY2 = 3'd4;

  typedef struct packed {
    logic       clear;
    logic       latch;
    logic       set_rd;
    logic       set_wr;
    logic       scan;
    logic       restart;
    logic       found;
    logic       give_none;
    logic       publish;
    logic [2:0] pass;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_set;
    logic set_ok;
    logic all_marked;
    logic step_last;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

// ===== design/ecpv_datapath.sv =====
`include "enhanced_clock_page_victim_assert.svh"

module ecpv_datapath #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          func,
  input  logic [ecpv_pkg::FRAME_W-1:0]  frame,
  input  logic [1:0]                    frame_state,
  input  logic                          use_bit,
  input  logic                          dirty_bit,
  input  logic                          out_stall,
  input  ecpv_pkg::cmd_t                cmd,
  output ecpv_pkg::stat_t               stat,
  output logic                          out_valid,
  output logic [ecpv_pkg::FRAME_W-1:0]  victim_frame,
  output logic                          victim_dirty,
  output logic                          none_available
);
  import ecpv_pkg::*;

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);

  logic [ENTRY_W-1:0] mem [NUM_FRAMES];

  logic [IDX_W-1:0]   frame_q;
  logic [1:0]         state_q;
  logic               use_q;
  logic               dirty_q;
  logic [IDX_W-1:0]   hand;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W:0]     step;
  logic [IDX_W-1:0]   ev_pos;
  logic [ENTRY_W-1:0] rdata;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   res_frame;
  logic               res_dirty;
  logic               res_none;

  logic [IDX_W:0]     pos_sum;
  logic [IDX_W:0]     pos_wrap;
  logic [IDX_W-1:0]   rd_addr;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [ENTRY_W-1:0] wd;
  logic [1:0]         r_st;
  logic               r_use;
  logic               r_dirty;
  logic               r_marked;
  logic               ev_valid;
  logic               hit_raw;
  logic               dirty_pass;

  assign r_st     = rdata[3:2];
  assign r_use    = rdata[1];
  assign r_dirty  = rdata[0];
  assign r_marked = (r_st == ST_MARKED);
  assign ev_valid = (step != '0);

  always_comb begin
    pos_sum = {1'b0, hand} + {1'b0, step[IDX_W-1:0]};
    if (pos_sum >= (IDX_W+1)'(NUM_FRAMES)) begin
      pos_wrap = pos_sum - (IDX_W+1)'(NUM_FRAMES);
    end else begin
      pos_wrap = pos_sum;
    end
    rd_addr = cmd.set_rd ? frame_q : pos_wrap[IDX_W-1:0];
  end

  always_comb begin
    dirty_pass = (cmd.pass == PASS_DIRTY1) || (cmd.pass == PASS_DIRTY2);
    case (cmd.pass)
      PASS_FREE:                hit_raw = (r_st == ST_FREE);
      PASS_CLEAN1, PASS_CLEAN2: hit_raw = !r_marked && !r_use && !r_dirty;
      PASS_DIRTY1, PASS_DIRTY2: hit_raw = !r_marked && !r_use && r_dirty;
      default:                  hit_raw = 1'b0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = ev_pos;
    wd = rdata;
    if (cmd.clear) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else if (cmd.set_wr) begin
      we = 1'b1;
      wa = frame_q;
      wd = {state_q, use_q, dirty_q};
    end else if (cmd.found) begin
      we = 1'b1;
      wd = {ST_MARKED, r_use, r_dirty};
    end else if (cmd.scan && ev_valid && dirty_pass && !hit_raw) begin
      // passing over a frame in a dirty pass takes its second chance away
      we = 1'b1;
      wd = {r_st, 1'b0, r_dirty};
    end
  end

  always_comb begin
    stat.clear_done = (clr_addr == IDX_W'(NUM_FRAMES - 1));
    stat.is_set     = func;
    stat.set_ok     = (32'(frame) < NUM_FRAMES);
    stat.all_marked = (cnt == CNT_W'(NUM_FRAMES));
    stat.step_last  = (step == (IDX_W+1)'(NUM_FRAMES));
    stat.hit        = ev_valid && hit_raw;
    stat.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata  <= mem[rd_addr];
    ev_pos <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      frame_q <= IDX_W'(frame);
      state_q <= frame_state;
      use_q   <= use_bit;
      dirty_q <= dirty_bit;
    end
    if (cmd.found) begin
      res_frame <= ev_pos;
      res_dirty <= r_dirty;
      res_none  <= 1'b0;
    end else if (cmd.give_none) begin
      res_frame <= '0;
      res_dirty <= 1'b0;
      res_none  <= 1'b1;
    end
    if (cmd.publish) begin
      victim_frame   <= FRAME_W'(res_frame);
      victim_dirty   <= res_dirty;
      none_available <= res_none;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hand      <= '0;
      clr_addr  <= '0;
      step      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.restart) begin
        step <= '0;
      end else if (cmd.scan) begin
        step <= step + 1'b1;
      end
      if (cmd.found) begin
        hand <= ev_pos;
        cnt  <= cnt + 1'b1;
      end else if (cmd.set_wr) begin
        if ((state_q == ST_MARKED) && !r_marked) begin
          cnt <= cnt + 1'b1;
        end else if ((state_q != ST_MARKED) && r_marked) begin
          cnt <= cnt - 1'b1;
        end
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ECPV_ASSERT_ALWAYS(a_cnt_range, 32'(cnt) <= NUM_FRAMES, "marked count above frame count")
  `ECPV_ASSERT_ALWAYS(a_hand_range, 32'(hand) < NUM_FRAMES, "clock hand out of range")
  `ECPV_ASSERT_NEXT(a_found_cnt, cmd.found, cnt == $past(cnt) + 1'b1, "victim not counted")
  `ECPV_ASSERT_IMP(a_publish_free, cmd.publish, !out_valid || !out_stall, "result overwritten")

endmodule

// ===== design/ecpv_controller.sv =====
module ecpv_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ecpv_pkg::stat_t stat,
  output ecpv_pkg::cmd_t  cmd
);
  import ecpv_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SET_RD = 3'd2;
  localparam logic [2:0] S_SET_WR = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] pass;
  logic [2:0] pass_next;

  always_comb begin
    cmd        = '0;
    cmd.pass   = pass;
    state_next = state;
    pass_next  = pass;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (stat.is_set) begin
            state_next = stat.set_ok ? S_SET_RD : S_IDLE;
          end else if (stat.all_marked) begin
            cmd.give_none = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.restart = 1'b1;
            pass_next   = PASS_FREE;
            state_next  = S_SCAN;
          end
        end
      end
      S_SET_RD: begin
        cmd.set_rd = 1'b1;
        state_next = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.set_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.found  = 1'b1;
          state_next = S_DONE;
        end else if (stat.step_last) begin
          cmd.restart = 1'b1;
          pass_next   = (pass == PASS_DIRTY2) ? PASS_CLEAN1 : pass + 3'd1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pass  <= PASS_FREE;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

endmodule

// ===== design/enhanced_clock_page_victim.sv =====
// Enhanced second-chance clock victim selector over NUM_FRAMES frames kept in one
// single-port-read memory of {status, use, dirty}. After reset a clearing pass
// frees every frame; no word is taken during it. A set word is accepted, its frame
// read, then written back; one whose frame is out of range is only accepted. A find
// word with every frame marked returns none_available. Otherwise the scan visits one
// frame per cycle through the memory read port, at most five passes (free, clean,
// dirty, clean, dirty); a result waits while an earlier one stays stalled in the
// output register, and the block takes the next word as soon as that register is
// loaded.
module enhanced_clock_page_victim #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [ecpv_pkg::FRAME_W-1:0]  frame,
  input  logic [1:0]                    frame_state,
  input  logic                          use_bit,
  input  logic                          dirty_bit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ecpv_pkg::FRAME_W-1:0]  victim_frame,
  output logic                          victim_dirty,
  output logic                          none_available
);
  import ecpv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ecpv_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ecpv_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .func           (func),
    .frame          (frame),
    .frame_state    (frame_state),
    .use_bit        (use_bit),
    .dirty_bit      (dirty_bit),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .victim_frame   (victim_frame),
    .victim_dirty   (victim_dirty),
    .none_available (none_available)
  );

endmodule
